[src/caption_line_waveform_generator_assert.svh]
// ----------------------------------------------------------------------------
// Caption line waveform generator assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef CAPTION_LINE_WAVEFORM_GENERATOR_ASSERT_SVH
`define CAPTION_LINE_WAVEFORM_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CWG_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cwg assertion failed");

// next-cycle implication, disabled during reset
`define CWG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cwg assertion failed");

`endif

[src/cwg_pkg.sv]
// ----------------------------------------------------------------------------
// Caption line waveform generator package
// Beat types, line layout constants and the run-in waveform table.
// ----------------------------------------------------------------------------
`default_nettype none

package cwg_pkg;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [9:0] sample_index;
    } req_t;

    typedef struct packed {
        logic [7:0] chroma_level;
        logic [7:0] luma_level;
    } rsp_t;

    localparam logic [7:0] LVL_LOW    = 8'h10;
    localparam logic [7:0] LVL_HIGH   = 8'h7E;
    localparam logic [7:0] CHROMA_MID = 8'h80;

    localparam logic [9:0] RUNIN_BEG = 10'd16;
    localparam logic [9:0] RUNIN_END = 10'd205;
    localparam logic [9:0] START_BEG = 10'd259;
    localparam logic [9:0] DATA_BEG  = 10'd286;
    localparam logic [9:0] DATA_END  = 10'd718;

    // offset / 27 == (offset * 607) >> 14 for offsets below 512
    localparam logic [9:0] DIV27_MUL = 10'd607;
    localparam logic [8:0] BIT_LEN   = 9'd27;

    function automatic logic [7:0] runin_level(input logic [4:0] phase);
        logic [7:0] lvl;
        case (phase)
            5'd0, 5'd25:  lvl = 8'd17;
            5'd1, 5'd24:  lvl = 8'd22;
            5'd2, 5'd23:  lvl = 8'd29;
            5'd3, 5'd22:  lvl = 8'd38;
            5'd4, 5'd21:  lvl = 8'd49;
            5'd5, 5'd20:  lvl = 8'd61;
            5'd6, 5'd19:  lvl = 8'd74;
            5'd7, 5'd18:  lvl = 8'd87;
            5'd8, 5'd17:  lvl = 8'd99;
            5'd9, 5'd16:  lvl = 8'd109;
            5'd10, 5'd15: lvl = 8'd117;
            5'd11, 5'd14: lvl = 8'd123;
            5'd12, 5'd13: lvl = 8'd126;
            default:      lvl = 8'd0;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

[src/cwg_luma.sv]
// ----------------------------------------------------------------------------
// Caption line luma decoder
// Maps a sample position and two caption bytes to the luma level.
// ----------------------------------------------------------------------------
`default_nettype none

module cwg_luma
    import cwg_pkg::*;
(
    input  wire req_t  req,
    output logic [7:0] luma
);

    logic [9:0]  idx;
    logic [9:0]  offset;
    logic [8:0]  offset9;
    logic [18:0] prod;
    logic [4:0]  quot;
    logic [8:0]  quot_x27;
    logic [4:0]  phase;
    logic [6:0]  data;
    logic [7:0]  bits;
    logic        bit_val;

    assign idx      = req.sample_index;
    assign offset   = (idx < DATA_BEG) ? (idx - RUNIN_BEG) : (idx - DATA_BEG);
    assign offset9  = offset[8:0];
    assign prod     = 19'(offset9) * 19'(DIV27_MUL);
    assign quot     = prod[18:14];
    assign quot_x27 = 9'(quot) * BIT_LEN;
    assign phase    = 5'(offset9 - quot_x27);

    // slots 0-7 first byte, 8-15 second byte; slots 7 and 15 (bit 7 of each byte) are odd parity
    assign data    = quot[3] ? req.second_byte[6:0] : req.first_byte[6:0];
    assign bits    = {~^data, data};
    assign bit_val = bits[quot[2:0]];

    always_comb
    begin
        if (idx < RUNIN_BEG)
            luma = LVL_LOW;
        else if (idx < RUNIN_END)
            luma = runin_level(phase);
        else if (idx < START_BEG)
            luma = LVL_LOW;
        else if (idx < DATA_BEG)
            luma = LVL_HIGH;
        else if (idx < DATA_END)
            luma = bit_val ? LVL_HIGH : LVL_LOW;
        else
            luma = LVL_LOW;
    end

endmodule

`default_nettype wire

[src/caption_line_waveform_generator.sv]
// ----------------------------------------------------------------------------
// Caption line waveform generator
// Produces one 4:2:2 sample pair of a line-21 caption waveform per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries two caption bytes
//   and a sample index 0..719. Response channel (rsp_valid/rsp_ready/rsp_data)
//   returns chroma 0x80 and the luma level at that index, one response per
//   request, in order.
//   A request lands in the input register, and the luma decode runs between
//   that register and the output register.
//   Throughput is one beat per cycle while rsp_ready stays high.
//   When the receiver stalls, the output register holds its beat and the
//   input register can still take one more request; req_ready drops once
//   both are full.
//   Reset empties both registers; nothing else holds state.
// ----------------------------------------------------------------------------
`default_nettype none

module caption_line_waveform_generator
    import cwg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp_data
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    req_t       s1_data_reg;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    rsp_t       rsp_data_reg;
    logic       s1_load;
    logic       rsp_load;
    logic [7:0] luma_calc;

    cwg_luma u_luma (
        .req  (s1_data_reg),
        .luma (luma_calc)
    );

    assign rsp_load  = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || rsp_load;
    assign s1_load   = req_valid && req_ready;

    assign s1_valid_next  = s1_load || (s1_valid_reg && !rsp_load);
    assign rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_data_reg <= req_data;
        if (rsp_load)
        begin
            rsp_data_reg.chroma_level <= CHROMA_MID;
            rsp_data_reg.luma_level   <= luma_calc;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

[src/cwg_checker.sv]
// ----------------------------------------------------------------------------
// Caption line waveform generator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "caption_line_waveform_generator_assert.svh"

module cwg_checker
    import cwg_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire req_t req_data,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp_data
);

    logic rsp_stall;
    logic req_stall;
    logic luma_legal;

    assign rsp_stall  = rsp_valid && !rsp_ready;
    assign req_stall  = req_valid && !req_ready;
    assign luma_legal = (rsp_data.luma_level == 8'd0) ||
                        ((rsp_data.luma_level >= LVL_LOW) &&
                         (rsp_data.luma_level <= LVL_HIGH));

    `CWG_ASSERT_NOW(a_chroma_mid, clk, rst_n, rsp_valid, rsp_data.chroma_level == CHROMA_MID)
    `CWG_ASSERT_NOW(a_luma_legal, clk, rst_n, rsp_valid, luma_legal)
    `CWG_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid)
    `CWG_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_stall, $stable(rsp_data))
    `CWG_ASSERT_NEXT(a_req_stable, clk, rst_n, req_stall, req_valid && $stable(req_data))

endmodule

bind caption_line_waveform_generator cwg_checker u_cwg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

`default_nettype wire

[verif/cwg_sample_checker.sv]
// ----------------------------------------------------------------------------
// Caption line sample checker
// Watches the request and response channels of the caption line waveform
// generator. It predicts the chroma/luma pair for every accepted request and
// compares every accepted response, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module cwg_sample_checker
    import cwg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_ready,
    input  wire req_t req_data,
    input  wire logic rsp_valid,
    input  wire logic rsp_ready,
    input  wire rsp_t rsp_data,
    output int        fail_count,
    output int        pending_count,
    output int        checked_count,
    output int        past_line_count,
    output int        input_stall_cycles
);

    typedef struct packed {
        logic [9:0] sample_index;
        rsp_t       pair;
    } expected_pair_t;

    // run-in cycle, phase 26 down to phase 0
    localparam logic [26:0][7:0] RUNIN_WAVE = {
        8'd0, 8'd17, 8'd22, 8'd29, 8'd38, 8'd49, 8'd61, 8'd74, 8'd87, 8'd99,
        8'd109, 8'd117, 8'd123, 8'd126, 8'd126, 8'd123, 8'd117, 8'd109,
        8'd99, 8'd87, 8'd74, 8'd61, 8'd49, 8'd38, 8'd29, 8'd22, 8'd17
    };

    expected_pair_t pair_q[$];
    expected_pair_t head;
    rsp_t           want;
    int             errors;
    int             checked;
    int             past_line;
    int             stalls;

    function automatic logic [7:0] data_bit_level(input logic [7:0] caption_byte,
                                                  input int bit_pos);
        logic [6:0] payload;
        payload = caption_byte[6:0];
        if (bit_pos < 7)
            return payload[bit_pos] ? LVL_HIGH : LVL_LOW;
        // odd parity over the eight sent bits
        return (^payload) ? LVL_LOW : LVL_HIGH;
    endfunction

    function automatic rsp_t predict_pair(input req_t beat);
        rsp_t pair;
        int   idx;
        int   slot;
        idx = beat.sample_index;
        pair.chroma_level = CHROMA_MID;
        if (idx < 16)
            pair.luma_level = LVL_LOW;
        else if (idx < 205)
            pair.luma_level = RUNIN_WAVE[(idx - 16) % 27];
        else if (idx < 259)
            pair.luma_level = LVL_LOW;
        else if (idx < 286)
            pair.luma_level = LVL_HIGH;
        else if (idx < 718)
        begin
            slot = (idx - 286) / 27;
            if (slot < 8)
                pair.luma_level = data_bit_level(beat.first_byte, slot);
            else
                pair.luma_level = data_bit_level(beat.second_byte, slot - 8);
        end
        else
            pair.luma_level = LVL_LOW;
        return pair;
    endfunction

    initial
    begin
        errors    = 0;
        checked   = 0;
        past_line = 0;
        stalls    = 0;
        fail_count         = 0;
        pending_count      = 0;
        checked_count      = 0;
        past_line_count    = 0;
        input_stall_cycles = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_ready)
                stalls++;
            if (req_valid && req_ready)
            begin
                want = predict_pair(req_data);
                pair_q.push_back({req_data.sample_index, want});
                if (req_data.sample_index > 10'd719)
                    past_line++;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (pair_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("check: response with nothing pending, chroma %02h luma %02h",
                                 rsp_data.chroma_level, rsp_data.luma_level);
                end
                else
                begin
                    head = pair_q.pop_front();
                    checked++;
                    if (rsp_data.chroma_level !== head.pair.chroma_level ||
                        rsp_data.luma_level !== head.pair.luma_level)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("check: idx %0d exp %02h/%02h got %02h/%02h",
                                     head.sample_index, head.pair.chroma_level,
                                     head.pair.luma_level, rsp_data.chroma_level,
                                     rsp_data.luma_level);
                    end
                end
            end
        end
        fail_count         <= errors;
        pending_count      <= pair_q.size();
        checked_count      <= checked;
        past_line_count    <= past_line;
        input_stall_cycles <= stalls;
    end

endmodule

`default_nettype wire

[verif/caption_line_waveform_generator_tb.sv]
// ----------------------------------------------------------------------------
// Caption line waveform generator testbench
// Drives directed samples across every region of the caption line, then
// random bytes and indices with random gaps and receiver stalls, one long
// receiver hold-off and two full drains. The sample checker scores the run.
// ----------------------------------------------------------------------------
`default_nettype none

module caption_line_waveform_generator_tb;
    import cwg_pkg::*;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_data;

    int fail_count;
    int pending_count;
    int checked_count;
    int past_line_count;
    int input_stall_cycles;
    int sent_count = 0;
    int rsp_beats  = 0;
    int longest_hold = 0;

    caption_line_waveform_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    cwg_sample_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid),
        .req_ready          (req_ready),
        .req_data           (req_data),
        .rsp_valid          (rsp_valid),
        .rsp_ready          (rsp_ready),
        .rsp_data           (rsp_data),
        .fail_count         (fail_count),
        .pending_count      (pending_count),
        .checked_count      (checked_count),
        .past_line_count    (past_line_count),
        .input_stall_cycles (input_stall_cycles)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    task automatic offer_sample(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [9:0] idx);
        int   gap;
        req_t beat;
        gap = (((sent_count / 50) % 4) == 1) ? 0 : $urandom_range(0, 9);
        beat.first_byte   = b0;
        beat.second_byte  = b1;
        beat.sample_index = idx;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= beat;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic wait_drained;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // receiver: per-beat stall, quiet stretches, one long hold-off
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (rsp_beats == 300)
                stall = 80;
            else if (((rsp_beats / 40) % 4) == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 9);
            if (stall > longest_hold)
                longest_hold = stall;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            rsp_beats++;
        end
    end

    initial
    begin
        logic [9:0] idx;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // line regions and their borders
        offer_sample(8'h00, 8'h00, 10'd0);
        offer_sample(8'hFF, 8'hFF, 10'd15);
        offer_sample(8'h55, 8'hAA, 10'd16);
        offer_sample(8'h55, 8'hAA, 10'd28);
        offer_sample(8'h55, 8'hAA, 10'd29);
        offer_sample(8'h00, 8'h00, 10'd42);   // zero sample closing a run-in cycle
        offer_sample(8'hFF, 8'h00, 10'd43);
        offer_sample(8'h00, 8'hFF, 10'd204);
        offer_sample(8'h7F, 8'h80, 10'd205);
        offer_sample(8'h80, 8'h7F, 10'd258);
        offer_sample(8'h00, 8'h00, 10'd259);
        offer_sample(8'h00, 8'h00, 10'd285);
        offer_sample(8'h01, 8'h00, 10'd286);
        offer_sample(8'hAA, 8'h55, 10'd512);
        // parity: even, odd, all seven ones, bit 7 ignored
        offer_sample(8'h00, 8'h00, 10'd475);
        offer_sample(8'h01, 8'h00, 10'd475);
        offer_sample(8'h7F, 8'h00, 10'd475);
        offer_sample(8'h00, 8'h03, 10'd691);
        offer_sample(8'h00, 8'hFE, 10'd691);
        offer_sample(8'h00, 8'h40, 10'd690);
        offer_sample(8'h00, 8'h00, 10'd717);
        offer_sample(8'hFF, 8'hFF, 10'd718);
        offer_sample(8'hFF, 8'hFF, 10'd719);
        // indices past the line
        offer_sample(8'hFF, 8'hFF, 10'd720);
        offer_sample(8'hFF, 8'hFF, 10'd1023);

        for (int i = 0; i < 800; i++)
        begin
            if (i == 400)
                wait_drained();
            if ($urandom_range(0, 9) == 0)
                idx = 10'($urandom_range(720, 1023));
            else
                idx = 10'($urandom_range(0, 719));
            offer_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), idx);
        end

        wait_drained();
        repeat (4) @(posedge clk);

        $display("run: %0d requests, %0d pairs checked, %0d indices past the line",
                 sent_count, checked_count, past_line_count);
        $display("run: input back-pressured %0d cycles, longest receiver hold %0d cycles",
                 input_stall_cycles, longest_hold);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
